@@ hw/rtl/dmwbc_pkg.sv @@
// ---------------------------------------------------------------------------
// dmwbc_pkg
// Shared types and constants for the direct-mapped write-back cache: op
// codes, cost register indexes and the controller/datapath interface.
// ---------------------------------------------------------------------------
`default_nettype none

package dmwbc_pkg;

    localparam int WORD_BYTES = 4;
    localparam int WORD_W     = 32;
    localparam int WORD_OFF_W = 2;
    localparam int ADDR_W     = 32;
    localparam int OP_W       = 2;
    localparam int COST_W     = 10;
    localparam int CFG_IDX_W  = 2;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DRAM_READ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAM_WRITE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_READ  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_WRITE = 2'd3;

    localparam logic [COST_W-1:0] RST_DRAM_READ   = 10'd100;
    localparam logic [COST_W-1:0] RST_DRAM_WRITE  = 10'd50;
    localparam logic [COST_W-1:0] RST_CACHE_READ  = 10'd1;
    localparam logic [COST_W-1:0] RST_CACHE_WRITE = 10'd1;

    typedef struct packed {
        logic capture;
        logic finish_hit;
        logic start_miss;
        logic finish_fill;
        logic clear_step;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic miss;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/dmwbc_ctrl.sv @@
// ---------------------------------------------------------------------------
// dmwbc_ctrl
// Controller: clearing pass after reset, word capture, tag lookup and the
// write-back / line fill sequence on a miss.
// ---------------------------------------------------------------------------
`default_nettype none

module dmwbc_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  dmwbc_pkg::t_sts i_sts,
    output dmwbc_pkg::t_cmd o_cmd
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;
    localparam logic [1:0] ST_FILL   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (i_sts.miss) begin
                    o_cmd.start_miss = 1'b1;
                    n_state          = ST_FILL;
                end else if (i_sts.out_free) begin
                    o_cmd.finish_hit = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_FILL: begin
                if (i_sts.out_free) begin
                    o_cmd.finish_fill = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dmwbc_dpath.sv @@
// ---------------------------------------------------------------------------
// dmwbc_dpath
// Datapath: tag store, line store, modelled DRAM, cost registers, time
// counter and the registered result word.
// ---------------------------------------------------------------------------
`default_nettype none

module dmwbc_dpath #(
    parameter int LINE_COUNT = 256,
    parameter int LINE_BYTES = 64,
    parameter int DRAM_BYTES = 1048576
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  dmwbc_pkg::t_cmd                      i_cmd,
    output dmwbc_pkg::t_sts                      o_sts,
    input  wire                                  i_cfg_wr_en,
    input  wire [dmwbc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [dmwbc_pkg::COST_W-1:0]          i_cfg_wr_data,
    input  wire [dmwbc_pkg::OP_W-1:0]            i_op,
    input  wire [dmwbc_pkg::ADDR_W-1:0]          i_address,
    input  wire [dmwbc_pkg::WORD_W-1:0]          i_write_data,
    input  wire                                  i_out_ready,
    output logic                                 o_out_valid,
    output logic [dmwbc_pkg::WORD_W-1:0]         o_read_data,
    output logic                                 o_hit,
    output logic                                 o_wrote_back,
    output logic                                 o_out_of_range,
    output logic [dmwbc_pkg::WORD_W-1:0]         o_elapsed_time
);

    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int IDX_W      = $clog2(LINE_COUNT);
    localparam int LNO_W      = dmwbc_pkg::ADDR_W - OFF_W;
    localparam int TAG_W      = LNO_W - IDX_W;
    localparam int LINE_W     = LINE_BYTES * 8;
    localparam int DRAM_LINES = DRAM_BYTES / LINE_BYTES;
    localparam int DROW_W     = $clog2(DRAM_LINES);
    localparam int CLR_ROWS   = (DRAM_LINES > LINE_COUNT) ? DRAM_LINES : LINE_COUNT;
    localparam int CLR_W      = $clog2(CLR_ROWS);
    localparam int WW         = dmwbc_pkg::WORD_W;
    localparam int WORD_OFF   = dmwbc_pkg::WORD_OFF_W;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } t_tag_entry;

    // storage
    t_tag_entry        mem_tag  [LINE_COUNT];
    logic [LINE_W-1:0] mem_line [LINE_COUNT];
    logic [LINE_W-1:0] mem_dram [DRAM_LINES];

    t_tag_entry        r_tag_q;
    logic [LINE_W-1:0] r_line_q;
    logic [LINE_W-1:0] r_dram_q;

    logic [dmwbc_pkg::OP_W-1:0]   r_op;
    logic [dmwbc_pkg::ADDR_W-1:0] r_addr;
    logic [WW-1:0]                r_wdata;
    logic                         r_wb;
    logic [CLR_W-1:0]             r_clr_cnt;

    logic [dmwbc_pkg::COST_W-1:0] r_dram_rd_cost;
    logic [dmwbc_pkg::COST_W-1:0] r_dram_wr_cost;
    logic [dmwbc_pkg::COST_W-1:0] r_cache_rd_cost;
    logic [dmwbc_pkg::COST_W-1:0] r_cache_wr_cost;

    logic          r_out_valid;
    logic [WW-1:0] r_rdata;
    logic          r_hit;
    logic          r_wb_out;
    logic          r_oor;
    logic [WW-1:0] r_time;

    logic [LNO_W-1:0]             w_line_no;
    logic [IDX_W-1:0]             w_idx;
    logic [TAG_W-1:0]             w_tag;
    logic [OFF_W-WORD_OFF-1:0]    w_wsel;
    logic                         w_is_rd;
    logic                         w_is_mem;
    logic                         w_in_range;
    logic                         w_hit;
    logic                         w_vic_dirty;
    logic [LNO_W-1:0]             w_vic_line;
    logic [dmwbc_pkg::COST_W-1:0] w_acc_cost;
    logic                         w_out_free;
    logic [LINE_W-1:0]            w_hit_line;
    logic [LINE_W-1:0]            w_fill_line;
    logic                         w_clr_tag;
    logic                         w_clr_dram;
    logic [IDX_W-1:0]             w_in_idx;

    logic                         w_tag_we;
    logic [IDX_W-1:0]             w_tag_wa;
    t_tag_entry                   w_tag_wd;
    logic                         w_line_we;
    logic [LINE_W-1:0]            w_line_wd;
    logic                         w_dram_we;
    logic [DROW_W-1:0]            w_dram_wa;
    logic [LINE_W-1:0]            w_dram_wd;

    logic          n_out_valid;
    logic [WW-1:0] n_rdata;
    logic          n_hit;
    logic          n_wb_out;
    logic          n_oor;
    logic [WW-1:0] n_time;

    assign w_line_no   = r_addr[dmwbc_pkg::ADDR_W-1:OFF_W];
    assign w_idx       = w_line_no[IDX_W-1:0];
    assign w_tag       = w_line_no[LNO_W-1:IDX_W];
    assign w_wsel      = r_addr[OFF_W-1:WORD_OFF];
    assign w_in_idx    = i_address[OFF_W +: IDX_W];
    assign w_is_rd     = (r_op == dmwbc_pkg::OP_READ);
    assign w_is_mem    = (r_op == dmwbc_pkg::OP_READ) || (r_op == dmwbc_pkg::OP_WRITE);
    assign w_in_range  = (w_line_no < LNO_W'(DRAM_LINES));
    assign w_hit       = r_tag_q.valid && (r_tag_q.tag == w_tag);
    assign w_vic_dirty = r_tag_q.valid && r_tag_q.dirty;
    assign w_vic_line  = {r_tag_q.tag, w_idx};
    assign w_acc_cost  = w_is_rd ? r_cache_rd_cost : r_cache_wr_cost;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_clr_tag   = ({1'b0, r_clr_cnt} < (CLR_W+1)'(LINE_COUNT));
    assign w_clr_dram  = ({1'b0, r_clr_cnt} < (CLR_W+1)'(DRAM_LINES));

    assign o_sts.clear_last = (r_clr_cnt == CLR_W'(CLR_ROWS - 1));
    assign o_sts.miss       = w_is_mem && w_in_range && !w_hit;
    assign o_sts.out_free   = w_out_free;

    // word merge into a line on writes
    always_comb begin
        w_hit_line  = r_line_q;
        w_fill_line = r_dram_q;
        if (!w_is_rd) begin
            w_hit_line[w_wsel*WW +: WW]  = r_wdata;
            w_fill_line[w_wsel*WW +: WW] = r_wdata;
        end
    end

    // store write ports
    always_comb begin
        w_tag_we  = 1'b0;
        w_tag_wa  = w_idx;
        w_tag_wd  = '{valid: 1'b1, dirty: !w_is_rd, tag: w_tag};
        w_line_we = 1'b0;
        w_line_wd = w_fill_line;
        w_dram_we = 1'b0;
        w_dram_wa = w_vic_line[DROW_W-1:0];
        w_dram_wd = r_line_q;
        if (i_cmd.clear_step) begin
            w_tag_we  = w_clr_tag;
            w_tag_wa  = r_clr_cnt[IDX_W-1:0];
            w_tag_wd  = '0;
            w_dram_we = w_clr_dram;
            w_dram_wa = r_clr_cnt[DROW_W-1:0];
            w_dram_wd = '0;
        end else if (i_cmd.finish_hit) begin
            w_tag_we  = w_is_mem && w_in_range && !w_is_rd;
            w_tag_wd  = '{valid: 1'b1, dirty: 1'b1, tag: w_tag};
            w_line_we = w_is_mem && w_in_range && !w_is_rd;
            w_line_wd = w_hit_line;
        end else if (i_cmd.start_miss) begin
            w_dram_we = w_vic_dirty;
        end else if (i_cmd.finish_fill) begin
            w_tag_we  = 1'b1;
            w_line_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            mem_tag[w_tag_wa] <= w_tag_wd;
        end
        if (i_cmd.capture) begin
            r_tag_q <= mem_tag[w_in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_line_we) begin
            mem_line[w_idx] <= w_line_wd;
        end
        if (i_cmd.capture) begin
            r_line_q <= mem_line[w_in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dram_we) begin
            mem_dram[w_dram_wa] <= w_dram_wd;
        end
        if (i_cmd.start_miss) begin
            r_dram_q <= mem_dram[w_line_no[DROW_W-1:0]];
        end
    end

    // captured word and miss bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        if (i_cmd.start_miss) begin
            r_wb <= w_vic_dirty;
        end
    end

    // result formation
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_rdata     = r_rdata;
        n_hit       = r_hit;
        n_wb_out    = r_wb_out;
        n_oor       = r_oor;
        n_time      = r_time;
        if (i_cmd.finish_hit) begin
            n_out_valid = 1'b1;
            n_rdata     = '0;
            n_hit       = 1'b0;
            n_wb_out    = 1'b0;
            n_oor       = 1'b0;
            if (r_op == dmwbc_pkg::OP_CLEAR) begin
                n_time = '0;
            end else if (w_is_mem && !w_in_range) begin
                n_oor = 1'b1;
            end else if (w_is_mem) begin
                n_hit  = 1'b1;
                n_time = r_time + WW'(w_acc_cost);
                if (w_is_rd) begin
                    n_rdata = r_line_q[w_wsel*WW +: WW];
                end
            end
        end else if (i_cmd.finish_fill) begin
            n_out_valid = 1'b1;
            n_rdata     = w_is_rd ? r_dram_q[w_wsel*WW +: WW] : '0;
            n_hit       = 1'b0;
            n_wb_out    = r_wb;
            n_oor       = 1'b0;
            n_time      = r_time + WW'(r_dram_rd_cost) + WW'(r_wb ? r_dram_wr_cost : '0)
                        + WW'(w_acc_cost);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_time      <= '0;
            r_clr_cnt   <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_time      <= n_time;
            if (i_cmd.clear_step) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata  <= n_rdata;
        r_hit    <= n_hit;
        r_wb_out <= n_wb_out;
        r_oor    <= n_oor;
    end

    // cost registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dram_rd_cost  <= dmwbc_pkg::RST_DRAM_READ;
            r_dram_wr_cost  <= dmwbc_pkg::RST_DRAM_WRITE;
            r_cache_rd_cost <= dmwbc_pkg::RST_CACHE_READ;
            r_cache_wr_cost <= dmwbc_pkg::RST_CACHE_WRITE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dmwbc_pkg::CFG_DRAM_READ:   r_dram_rd_cost  <= i_cfg_wr_data;
                dmwbc_pkg::CFG_DRAM_WRITE:  r_dram_wr_cost  <= i_cfg_wr_data;
                dmwbc_pkg::CFG_CACHE_READ:  r_cache_rd_cost <= i_cfg_wr_data;
                dmwbc_pkg::CFG_CACHE_WRITE: r_cache_wr_cost <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_rdata;
    assign o_hit          = r_hit;
    assign o_wrote_back   = r_wb_out;
    assign o_out_of_range = r_oor;
    assign o_elapsed_time = r_time;

endmodule

`default_nettype wire

@@ hw/rtl/direct_mapped_writeback_cache.sv @@
// ---------------------------------------------------------------------------
// direct_mapped_writeback_cache
// Direct-mapped, write-back, write-allocate cache in front of a modelled
// DRAM, with configurable access costs summed into a time counter.
// ---------------------------------------------------------------------------
// result: registered after the lookup on a hit, clear or out-of-range word,
//   after the fill on a miss, and held back while the last result is not taken
// flow: one word at a time, no new word accepted until its result is formed;
//   steps are tag lookup, then victim write-back with line fetch, then fill
// reset: a clearing pass over max(DRAM lines, cache lines) rows (16384 at
//   the default sizes), during which no word is accepted
// ---------------------------------------------------------------------------
`default_nettype none

module direct_mapped_writeback_cache #(
    parameter int LINE_COUNT = 256,
    parameter int LINE_BYTES = 64,
    parameter int DRAM_BYTES = 1048576
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire [dmwbc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [dmwbc_pkg::COST_W-1:0]          i_cfg_wr_data,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire [dmwbc_pkg::OP_W-1:0]            i_op,
    input  wire [dmwbc_pkg::ADDR_W-1:0]          i_address,
    input  wire [dmwbc_pkg::WORD_W-1:0]          i_write_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [dmwbc_pkg::WORD_W-1:0]         o_read_data,
    output logic                                 o_hit,
    output logic                                 o_wrote_back,
    output logic                                 o_out_of_range,
    output logic [dmwbc_pkg::WORD_W-1:0]         o_elapsed_time
);

    dmwbc_pkg::t_cmd cmd;
    dmwbc_pkg::t_sts sts;

    dmwbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dmwbc_dpath #(
        .LINE_COUNT (LINE_COUNT),
        .LINE_BYTES (LINE_BYTES),
        .DRAM_BYTES (DRAM_BYTES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_op           (i_op),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_read_data    (o_read_data),
        .o_hit          (o_hit),
        .o_wrote_back   (o_wrote_back),
        .o_out_of_range (o_out_of_range),
        .o_elapsed_time (o_elapsed_time)
    );

    a_cmd_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.capture, cmd.finish_hit, cmd.start_miss, cmd.finish_fill,
                  cmd.clear_step}))
        else $error("controller issued overlapping commands");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("new word accepted during lookup");

    a_wb_not_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_wrote_back))
        else $error("write-back reported on a hit");

    a_oor_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (!o_hit && !o_wrote_back && o_read_data == '0))
        else $error("out-of-range word carries access results");

endmodule

`default_nettype wire
